@@ hw/rtl/kawasaki_two_temperature_exchange_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef KAWASAKI_TWO_TEMPERATURE_EXCHANGE_MACROS_SVH
`define KAWASAKI_TWO_TEMPERATURE_EXCHANGE_MACROS_SVH

`ifndef SYNTHESIS
`define KTTE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KTTE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KTTE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define KTTE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hw/rtl/ktte_pkg.sv @@
package ktte_pkg;

    localparam int SIDE_DEFAULT          = 64;
    localparam int FRACTION_BITS_DEFAULT = 24;

    localparam int OP_W        = 2;
    localparam int DIR_W       = 2;
    localparam int COORD_W     = 6;
    localparam int ROLL_W      = 24;
    localparam int ENERGY_W    = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 25;
    localparam int REG_COUNT   = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_VERT_1 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VERT_2 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VERT_3 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HORZ_1 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HORZ_2 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HORZ_3 = 3'd5;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_SHUFFLE = 2'd2,
        OP_METRO   = 2'd3
    } op_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_EVAL,
        S_WR_A,
        S_WR_B,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                swap;
        logic                write_a;
        logic                write_b;
        logic                site;
        logic [ENERGY_W-1:0] energy;
    } eval_res_t;

endpackage

@@ hw/rtl/ktte_ram.sv @@
module ktte_ram #(
    parameter int WIDTH = ktte_pkg::SIDE_DEFAULT,
    parameter int DEPTH = ktte_pkg::SIDE_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/ktte_eval.sv @@
module ktte_eval #(
    parameter int SIDE          = ktte_pkg::SIDE_DEFAULT,
    parameter int FRACTION_BITS = ktte_pkg::FRACTION_BITS_DEFAULT
) (
    input  ktte_pkg::op_t                                op,
    input  ktte_pkg::dir_t                               dir,
    input  logic [$clog2(SIDE)-1:0]                      col,
    input  logic                                         wr_occ,
    input  logic [FRACTION_BITS-1:0]                     roll,
    input  logic [ktte_pkg::REG_COUNT-1:0][FRACTION_BITS:0] thr,
    input  logic [SIDE-1:0]                              row_up,
    input  logic [SIDE-1:0]                              row_mid,
    input  logic [SIDE-1:0]                              row_dn,
    input  logic [SIDE-1:0]                              row_far,
    output ktte_pkg::eval_res_t                          res,
    output logic [SIDE-1:0]                              row_a,
    output logic [SIDE-1:0]                              row_b
);

    import ktte_pkg::*;

    localparam int COL_W = $clog2(SIDE);

    function automatic logic [COL_W-1:0] wrap_inc(input logic [COL_W-1:0] v);
        wrap_inc = (v == COL_W'(SIDE - 1)) ? '0 : v + COL_W'(1);
    endfunction

    function automatic logic [COL_W-1:0] wrap_dec(input logic [COL_W-1:0] v);
        wrap_dec = (v == '0) ? COL_W'(SIDE - 1) : v - COL_W'(1);
    endfunction

    logic [COL_W-1:0]     cm, cp, cmm, cpp, pc;
    logic                 si, sk, differ, vertical, positive, accept, swap;
    logic [1:0]           ni, nk;
    logic signed [2:0]    d, half;
    logic [FRACTION_BITS:0] thr_sel;
    logic [SIDE-1:0]      hot_c, hot_p;

    assign cm  = wrap_dec(col);
    assign cp  = wrap_inc(col);
    assign cmm = wrap_dec(cm);
    assign cpp = wrap_inc(cp);
    assign si  = row_mid[col];
    assign vertical = (dir == DIR_UP) || (dir == DIR_DOWN);

    always_comb begin
        unique case (dir)
            DIR_UP: begin
                sk = row_up[col];
                pc = col;
                ni = 2'(row_dn[col]) + 2'(row_mid[cm]) + 2'(row_mid[cp]);
                nk = 2'(row_far[col]) + 2'(row_up[cm]) + 2'(row_up[cp]);
            end
            DIR_DOWN: begin
                sk = row_dn[col];
                pc = col;
                ni = 2'(row_up[col]) + 2'(row_mid[cm]) + 2'(row_mid[cp]);
                nk = 2'(row_far[col]) + 2'(row_dn[cm]) + 2'(row_dn[cp]);
            end
            DIR_RIGHT: begin
                sk = row_mid[cp];
                pc = cp;
                ni = 2'(row_up[col]) + 2'(row_dn[col]) + 2'(row_mid[cm]);
                nk = 2'(row_up[cp]) + 2'(row_dn[cp]) + 2'(row_mid[cpp]);
            end
            DIR_LEFT: begin
                sk = row_mid[cm];
                pc = cm;
                ni = 2'(row_up[col]) + 2'(row_dn[col]) + 2'(row_mid[cp]);
                nk = 2'(row_up[cm]) + 2'(row_dn[cm]) + 2'(row_mid[cmm]);
            end
            default: begin
                sk = 1'b0;
                pc = col;
                ni = 2'd0;
                nk = 2'd0;
            end
        endcase
    end

    assign differ   = si ^ sk;
    assign d        = $signed({1'b0, ni}) - $signed({1'b0, nk});
    assign half     = si ? d : -d;
    assign positive = (half > 3'sd0);

    always_comb begin
        case (half)
            3'sd1:   thr_sel = vertical ? thr[REG_VERT_1] : thr[REG_HORZ_1];
            3'sd2:   thr_sel = vertical ? thr[REG_VERT_2] : thr[REG_HORZ_2];
            3'sd3:   thr_sel = vertical ? thr[REG_VERT_3] : thr[REG_HORZ_3];
            default: thr_sel = '0;
        endcase
    end

    assign accept = !positive || ({1'b0, roll} < thr_sel);
    assign swap   = differ && ((op == OP_SHUFFLE) || ((op == OP_METRO) && accept));

    assign hot_c = SIDE'(1) << col;
    assign hot_p = SIDE'(1) << pc;

    always_comb begin
        res.swap    = swap;
        res.write_a = (op == OP_WRITE) || swap;
        res.write_b = swap && vertical;
        res.site    = si;
        res.energy  = ((op == OP_METRO) && differ) ? ENERGY_W'({half, 1'b0}) : '0;
        if (op == OP_WRITE) begin
            row_a = (row_mid & ~hot_c) | (wr_occ ? hot_c : '0);
        end else if (vertical) begin
            row_a = row_mid ^ hot_c;
        end else begin
            row_a = row_mid ^ hot_c ^ hot_p;
        end
        row_b = ((dir == DIR_UP) ? row_up : row_dn) ^ hot_c;
    end

endmodule

@@ hw/rtl/kawasaki_two_temperature_exchange.sv @@
// Kawasaki-exchange Metropolis engine on a periodic SIDE x SIDE lattice of one-bit
// occupancies, cleared to holes at reset. The lattice lives in a row-wide memory
// (one row per word) with one read and one write port; a valid bit per row makes
// unwritten rows read as holes, so no clearing pass follows reset. Each item fetches
// the neighborhood rows one per cycle through the single read port (three rows, four
// for a vertical exchange), evaluates the move, and writes back up to two rows.
// The result is registered after the row fetch, a wait state (S_WAIT), the evaluation
// (S_EVAL), the write-back state for the first row (S_WR_A) and, when it swaps
// vertically, the one for the partner row (S_WR_B). The block then returns to idle and
// takes the next item once that result is registered, even if it has not been taken
// yet, so items are handled one at a time; a result still waiting when the next one is ready holds the block.
// Threshold registers are to be written only while the block is idle; the block itself does not enforce this.
`include "kawasaki_two_temperature_exchange_macros.svh"

module kawasaki_two_temperature_exchange #(
    parameter int SIDE          = ktte_pkg::SIDE_DEFAULT,
    parameter int FRACTION_BITS = ktte_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic [ktte_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ktte_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ktte_pkg::OP_W-1:0]           s_operation,
    input  logic [ktte_pkg::COORD_W-1:0]        s_row,
    input  logic [ktte_pkg::COORD_W-1:0]        s_col,
    input  logic [ktte_pkg::DIR_W-1:0]          s_direction,
    input  logic [ktte_pkg::ROLL_W-1:0]         s_roll,
    input  logic                                s_write_occupancy,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_swapped,
    output logic                                m_site_occupancy,
    output logic signed [ktte_pkg::ENERGY_W-1:0] m_energy_change
);

    import ktte_pkg::*;

    localparam int ROW_W   = $clog2(SIDE);
    localparam int COORD_N = 1 << COORD_W;
    localparam int RW      = (FRACTION_BITS > ROLL_W) ? FRACTION_BITS : ROLL_W;
    localparam int DW      = (FRACTION_BITS + 1 > CFG_DATA_W) ? FRACTION_BITS + 1 : CFG_DATA_W;
    localparam logic [DW-1:0] RST_WIDE = DW'(25'h100_0000);
    localparam logic [FRACTION_BITS:0] THR_RST =
        (FRACTION_BITS >= 24) ? RST_WIDE[FRACTION_BITS:0] : '1;

    localparam logic [1:0] SLOT_UP  = 2'd0;
    localparam logic [1:0] SLOT_MID = 2'd1;
    localparam logic [1:0] SLOT_DN  = 2'd2;
    localparam logic [1:0] SLOT_FAR = 2'd3;

    function automatic logic [ROW_W-1:0] wrap_inc(input logic [ROW_W-1:0] v);
        wrap_inc = (v == ROW_W'(SIDE - 1)) ? '0 : v + ROW_W'(1);
    endfunction

    function automatic logic [ROW_W-1:0] wrap_dec(input logic [ROW_W-1:0] v);
        wrap_dec = (v == '0) ? ROW_W'(SIDE - 1) : v - ROW_W'(1);
    endfunction

    logic [ROW_W-1:0] mod_tbl [COORD_N];

    for (genvar i = 0; i < COORD_N; i++) begin : g_mod
        assign mod_tbl[i] = ROW_W'(i % SIDE);
    end

    state_t                 state_reg, state_next;
    logic [1:0]             k_reg, k_next;
    logic                   rd_en_reg;
    logic [1:0]             rd_slot_reg;
    logic                   rd_vld_reg;
    logic [SIDE-1:0]        row_valid_reg;
    logic [REG_COUNT-1:0][FRACTION_BITS:0] thr_reg;
    logic                   m_valid_reg;

    op_t                    op_reg;
    dir_t                   dir_reg;
    logic [ROW_W-1:0]       r_reg, c_reg;
    logic [FRACTION_BITS-1:0] roll_reg;
    logic                   wocc_reg;
    logic [SIDE-1:0]        win_reg [4];
    eval_res_t              res_reg;
    logic [SIDE-1:0]        row_a_reg, row_b_reg;
    logic                   m_swapped_reg, m_site_reg;
    logic [ENERGY_W-1:0]    m_energy_reg;

    logic [RW-1:0]          roll_wide;
    logic [DW-1:0]          cfg_wide;
    logic [ROW_W-1:0]       rm1, rp1, rm2, rp2;
    logic                   vertical, needs_far, last_read, out_free;
    logic                   ram_rd_en, ram_wr_en, load_out;
    logic [ROW_W-1:0]       ram_rd_addr, ram_wr_addr;
    logic [SIDE-1:0]        ram_wr_data, ram_rd_data;
    eval_res_t              eval_res;
    logic [SIDE-1:0]        eval_row_a, eval_row_b;

    assign roll_wide = RW'(s_roll);
    assign cfg_wide  = DW'(cfg_wdata);
    assign rm1       = wrap_dec(r_reg);
    assign rp1       = wrap_inc(r_reg);
    assign rm2       = wrap_dec(rm1);
    assign rp2       = wrap_inc(rp1);
    assign vertical  = (dir_reg == DIR_UP) || (dir_reg == DIR_DOWN);
    assign needs_far = vertical && ((op_reg == OP_SHUFFLE) || (op_reg == OP_METRO));
    assign last_read = (k_reg == (needs_far ? SLOT_FAR : SLOT_DN));
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_READ;
            S_READ: if (last_read) state_next = S_WAIT;
            S_WAIT: state_next = S_EVAL;
            S_EVAL: state_next = S_WR_A;
            S_WR_A: state_next = res_reg.write_b ? S_WR_B : S_DONE;
            S_WR_B: state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        ram_rd_en   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_reg;
        ram_wr_data = row_a_reg;
        load_out    = 1'b0;
        k_next      = k_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                k_next  = SLOT_UP;
            end
            S_READ: begin
                ram_rd_en = 1'b1;
                k_next    = k_reg + 2'd1;
            end
            S_WR_A: ram_wr_en = res_reg.write_a;
            S_WR_B: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = (dir_reg == DIR_UP) ? rm1 : rp1;
                ram_wr_data = row_b_reg;
            end
            S_DONE: load_out = out_free;
            default: ;
        endcase
    end

    always_comb begin
        case (k_reg)
            SLOT_UP:  ram_rd_addr = rm1;
            SLOT_MID: ram_rd_addr = r_reg;
            SLOT_DN:  ram_rd_addr = rp1;
            default:  ram_rd_addr = (dir_reg == DIR_UP) ? rm2 : rp2;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            k_reg         <= SLOT_UP;
            rd_en_reg     <= 1'b0;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                thr_reg[i] <= THR_RST;
            end
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            rd_en_reg <= ram_rd_en;
            if (ram_wr_en) begin
                row_valid_reg[ram_wr_addr] <= 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_VERT_1: thr_reg[REG_VERT_1] <= cfg_wide[FRACTION_BITS:0];
                    REG_VERT_2: thr_reg[REG_VERT_2] <= cfg_wide[FRACTION_BITS:0];
                    REG_VERT_3: thr_reg[REG_VERT_3] <= cfg_wide[FRACTION_BITS:0];
                    REG_HORZ_1: thr_reg[REG_HORZ_1] <= cfg_wide[FRACTION_BITS:0];
                    REG_HORZ_2: thr_reg[REG_HORZ_2] <= cfg_wide[FRACTION_BITS:0];
                    REG_HORZ_3: thr_reg[REG_HORZ_3] <= cfg_wide[FRACTION_BITS:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= op_t'(s_operation);
            dir_reg  <= dir_t'(s_direction);
            r_reg    <= mod_tbl[s_row];
            c_reg    <= mod_tbl[s_col];
            roll_reg <= roll_wide[FRACTION_BITS-1:0];
            wocc_reg <= s_write_occupancy;
        end
        if (ram_rd_en) begin
            rd_slot_reg <= k_reg;
            rd_vld_reg  <= row_valid_reg[ram_rd_addr];
        end
        if (rd_en_reg) begin
            win_reg[rd_slot_reg] <= rd_vld_reg ? ram_rd_data : '0;
        end
        if (state_reg == S_EVAL) begin
            res_reg   <= eval_res;
            row_a_reg <= eval_row_a;
            row_b_reg <= eval_row_b;
        end
        if (load_out) begin
            m_swapped_reg <= res_reg.swap;
            m_site_reg    <= res_reg.site;
            m_energy_reg  <= res_reg.energy;
        end
    end

    ktte_ram #(
        .WIDTH (SIDE),
        .DEPTH (SIDE)
    ) u_lattice (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ktte_eval #(
        .SIDE          (SIDE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_eval (
        .op      (op_reg),
        .dir     (dir_reg),
        .col     (c_reg),
        .wr_occ  (wocc_reg),
        .roll    (roll_reg),
        .thr     (thr_reg),
        .row_up  (win_reg[SLOT_UP]),
        .row_mid (win_reg[SLOT_MID]),
        .row_dn  (win_reg[SLOT_DN]),
        .row_far (win_reg[SLOT_FAR]),
        .res     (eval_res),
        .row_a   (eval_row_a),
        .row_b   (eval_row_b)
    );

    assign m_valid          = m_valid_reg;
    assign m_swapped        = m_swapped_reg;
    assign m_site_occupancy = m_site_reg;
    assign m_energy_change  = $signed(m_energy_reg);

    `KTTE_ASSERT_NXT(a_accept_starts_read, aclk, aresetn,
        s_valid && s_ready, state_reg == S_READ,
        "accepted beat did not start a row fetch")
    `KTTE_ASSERT_IMP(a_second_write_follows_first, aclk, aresetn,
        state_reg == S_WR_B, $past(state_reg) == S_WR_A,
        "partner row written out of order")
    `KTTE_ASSERT_IMP(a_write_only_in_writeback, aclk, aresetn,
        ram_wr_en, state_reg == S_WR_A || state_reg == S_WR_B,
        "lattice written outside write-back")
    `KTTE_ASSERT_IMP(a_energy_only_metro, aclk, aresetn,
        state_reg == S_DONE && res_reg.energy != '0, op_reg == OP_METRO,
        "energy change reported for a non-Metropolis beat")

endmodule

@@ bench/tb_kawasaki_two_temperature_exchange.sv @@
module tb_kawasaki_two_temperature_exchange;
    timeunit 1ns;
    timeprecision 1ps;

    import ktte_pkg::*;

    localparam int SIDE             = SIDE_DEFAULT;
    localparam int CLK_HALF_NS      = 2;
    localparam int RESET_CYCLES     = 7;
    localparam int PHASES           = 6;
    localparam int ITEMS_PER_PHASE  = 200;
    localparam int SETTLE_CYCLES    = 16;
    localparam int LIMIT_NS         = 2_000_000;
    localparam logic [CFG_DATA_W-1:0] UNITY = CFG_DATA_W'(1) << FRACTION_BITS_DEFAULT;

    typedef struct {
        op_t                op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        dir_t               dir;
        logic [ROLL_W-1:0]  roll;
        logic               wocc;
    } site_item_t;

    typedef struct {
        logic                       swapped;
        logic                       site;
        logic signed [ENERGY_W-1:0] energy;
    } site_result_t;

    logic                        aclk              = 1'b0;
    logic                        aresetn           = 1'b0;
    logic                        cfg_we            = 1'b0;
    logic [CFG_INDEX_W-1:0]      cfg_index         = '0;
    logic [CFG_DATA_W-1:0]       cfg_wdata         = '0;
    logic                        s_valid           = 1'b0;
    logic                        s_ready;
    logic [OP_W-1:0]             s_operation       = '0;
    logic [COORD_W-1:0]          s_row             = '0;
    logic [COORD_W-1:0]          s_col             = '0;
    logic [DIR_W-1:0]            s_direction       = '0;
    logic [ROLL_W-1:0]           s_roll            = '0;
    logic                        s_write_occupancy = 1'b0;
    logic                        m_valid;
    logic                        m_ready           = 1'b0;
    logic                        m_swapped;
    logic                        m_site_occupancy;
    logic signed [ENERGY_W-1:0]  m_energy_change;

    logic                        occupancy [SIDE*SIDE];
    logic [CFG_DATA_W-1:0]       accept_limit [REG_COUNT];
    site_item_t                  pending_items [$];
    site_result_t                expected_results [$];
    site_item_t                  beat_in_flight;
    site_result_t                predicted;
    site_result_t                oldest;
    int                          send_idle_pct = 9;
    int                          recv_idle_pct = 75;
    int                          mismatch_count = 0;

    kawasaki_two_temperature_exchange u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_row             (s_row),
        .s_col             (s_col),
        .s_direction       (s_direction),
        .s_roll            (s_roll),
        .s_write_occupancy (s_write_occupancy),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_swapped         (m_swapped),
        .m_site_occupancy  (m_site_occupancy),
        .m_energy_change   (m_energy_change)
    );

    always begin
        #(CLK_HALF_NS) aclk = 1'b1;
        #(CLK_HALF_NS) aclk = 1'b0;
    end

    initial begin
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int spin(int r, int c);
        return occupancy[(r % SIDE) * SIDE + (c % SIDE)] ? 1 : -1;
    endfunction

    function automatic int neighbor_spin_sum(int r, int c);
        return spin(r + SIDE - 1, c) + spin(r + 1, c) + spin(r, c + SIDE - 1) + spin(r, c + 1);
    endfunction

    task automatic predict_exchange(input site_item_t it, output site_result_t res);
        int   r;
        int   c;
        int   pr;
        int   pc;
        int   si;
        int   sk;
        int   ediff;
        int   half;
        int   sel;
        logic accept;
        logic held;
        r     = it.row % SIDE;
        c     = it.col % SIDE;
        pr    = r;
        pc    = c;
        ediff = 0;
        res.swapped = 1'b0;
        res.site    = occupancy[r*SIDE + c];
        case (it.op)
            OP_WRITE: begin
                occupancy[r*SIDE + c] = it.wocc;
            end
            OP_SHUFFLE, OP_METRO: begin
                case (it.dir)
                    DIR_UP:    pr = (r + SIDE - 1) % SIDE;
                    DIR_DOWN:  pr = (r + 1) % SIDE;
                    DIR_RIGHT: pc = (c + 1) % SIDE;
                    default:   pc = (c + SIDE - 1) % SIDE;
                endcase
                if (occupancy[r*SIDE + c] != occupancy[pr*SIDE + pc]) begin
                    accept = 1'b1;
                    if (it.op == OP_METRO) begin
                        si    = spin(r, c);
                        sk    = spin(pr, pc);
                        ediff = (neighbor_spin_sum(r, c) - sk) * si
                              + (neighbor_spin_sum(pr, pc) - si) * sk;
                        half  = ediff / 2;
                        if (half >= 1 && half <= 3) begin
                            sel    = (it.dir == DIR_UP || it.dir == DIR_DOWN) ?
                                     REG_VERT_1 : REG_HORZ_1;
                            accept = {1'b0, it.roll} < accept_limit[sel + half - 1];
                        end
                    end
                    if (accept) begin
                        held                    = occupancy[r*SIDE + c];
                        occupancy[r*SIDE + c]   = occupancy[pr*SIDE + pc];
                        occupancy[pr*SIDE + pc] = held;
                        res.swapped             = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.energy = ENERGY_W'(ediff);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // drive input beats; predict each accepted one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_exchange(beat_in_flight, predicted);
                expected_results.push_back(predicted);
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    beat_in_flight = pending_items.pop_front();
                    s_valid           <= 1'b1;
                    s_operation       <= beat_in_flight.op;
                    s_row             <= beat_in_flight.row;
                    s_col             <= beat_in_flight.col;
                    s_direction       <= beat_in_flight.dir;
                    s_roll            <= beat_in_flight.roll;
                    s_write_occupancy <= beat_in_flight.wocc;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // check result beats in order
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    oldest = expected_results.pop_front();
                    if (m_swapped !== oldest.swapped)
                        report_mismatch($sformatf("swapped got %b want %b",
                                                  m_swapped, oldest.swapped));
                    if (m_site_occupancy !== oldest.site)
                        report_mismatch($sformatf("site_occupancy got %b want %b",
                                                  m_site_occupancy, oldest.site));
                    if (m_energy_change !== oldest.energy)
                        report_mismatch($sformatf("energy_change got %0d want %0d",
                                                  m_energy_change, oldest.energy));
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic queue_item(input op_t op, input int row, input int col, input dir_t dir,
                              input logic [ROLL_W-1:0] roll, input logic wocc);
        site_item_t it;
        it.op   = op;
        it.row  = COORD_W'(row);
        it.col  = COORD_W'(col);
        it.dir  = dir;
        it.roll = roll;
        it.wocc = wocc;
        pending_items.push_back(it);
    endtask

    task automatic queue_random_item(input int hot_row, input int hot_col);
        site_item_t            it;
        int                    pick;
        logic [CFG_DATA_W-1:0] near;
        pick  = $urandom_range(0, 99);
        it.op = pick < 20 ? OP_WRITE : pick < 30 ? OP_READ : pick < 50 ? OP_SHUFFLE : OP_METRO;
        if ($urandom_range(0, 3) != 0) begin
            it.row = COORD_W'((hot_row + $urandom_range(0, 7)) % SIDE);
            it.col = COORD_W'((hot_col + $urandom_range(0, 7)) % SIDE);
        end else begin
            it.row = COORD_W'($urandom);
            it.col = COORD_W'($urandom);
        end
        it.dir = dir_t'($urandom_range(0, 3));
        pick   = $urandom_range(0, 9);
        if (pick < 2) begin
            near    = accept_limit[$urandom_range(0, REG_COUNT-1)]
                    + CFG_DATA_W'($urandom_range(0, 2)) - 1'b1;
            it.roll = near[ROLL_W-1:0];
        end else if (pick == 2) begin
            it.roll = $urandom_range(0, 1) ? '1 : '0;
        end else begin
            it.roll = ROLL_W'($urandom);
        end
        it.wocc = 1'($urandom_range(0, 1));
        pending_items.push_back(it);
    endtask

    task automatic set_threshold(input int idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INDEX_W'(idx);
        cfg_wdata <= value;
        if (idx < REG_COUNT)
            accept_limit[idx] = value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_threshold(int phase, int idx);
        case (phase)
            1: return '0;
            2: return '1;
            3: return idx < REG_HORZ_1 ? UNITY : UNITY - 1'b1;
            4: return idx < REG_HORZ_1 ? UNITY >> (idx + 1) : CFG_DATA_W'(1);
            default: return CFG_DATA_W'($urandom_range(0, UNITY));
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int hot_row;
        int hot_col;
        for (int i = 0; i < SIDE*SIDE; i++)
            occupancy[i] = 1'b0;
        for (int i = 0; i < REG_COUNT; i++)
            accept_limit[i] = UNITY;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        queue_item(OP_READ,     0,  0,  DIR_UP,    '0, 1'b0);
        queue_item(OP_WRITE,    63, 63, DIR_LEFT,  '1, 1'b1);
        queue_item(OP_WRITE,    0,  0,  DIR_DOWN,  '0, 1'b1);
        queue_item(OP_READ,     63, 63, DIR_RIGHT, '0, 1'b0);
        queue_item(OP_SHUFFLE,  0,  0,  DIR_UP,    '0, 1'b0);
        queue_item(OP_SHUFFLE,  63, 63, DIR_RIGHT, '1, 1'b0);
        queue_item(OP_SHUFFLE,  63, 63, DIR_DOWN,  '0, 1'b0);
        queue_item(OP_SHUFFLE,  0,  63, DIR_RIGHT, '0, 1'b0);
        queue_item(OP_SHUFFLE,  0,  0,  DIR_LEFT,  '0, 1'b0);
        queue_item(OP_METRO,    10, 10, DIR_DOWN,  '1, 1'b1);
        queue_item(OP_SHUFFLE,  10, 10, DIR_UP,    '1, 1'b1);
        queue_item(OP_WRITE,    30, 30, DIR_UP,    '0, 1'b1);
        queue_item(OP_WRITE,    30, 31, DIR_UP,    '0, 1'b1);
        queue_item(OP_METRO,    30, 31, DIR_RIGHT, '1, 1'b0);
        queue_item(OP_METRO,    30, 32, DIR_LEFT,  '0, 1'b0);
        queue_item(OP_WRITE,    40, 40, DIR_UP,    '0, 1'b1);
        queue_item(OP_METRO,    40, 40, DIR_UP,    '1, 1'b0);
        queue_item(OP_WRITE,    50, 6,  DIR_UP,    '0, 1'b1);
        queue_item(OP_WRITE,    51, 5,  DIR_UP,    '0, 1'b1);
        queue_item(OP_WRITE,    49, 5,  DIR_UP,    '0, 1'b1);
        queue_item(OP_METRO,    50, 5,  DIR_LEFT,  '0, 1'b0);
        queue_item(OP_METRO,    50, 4,  DIR_RIGHT, '1, 1'b0);
        queue_item(OP_WRITE,    63, 63, DIR_UP,    '1, 1'b0);
        queue_item(OP_READ,     63, 0,  DIR_DOWN,  '1, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            for (int i = 0; i < REG_COUNT; i++)
                set_threshold(i, pick_threshold(p, i));
            if (p == 2) begin
                for (int i = REG_COUNT; i < 2**CFG_INDEX_W; i++)
                    set_threshold(i, '0);
            end
            case (p / 2)
                0: begin
                    send_idle_pct = 9;
                    recv_idle_pct = 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct = 9;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            hot_row = (p % 2 == 0) ? SIDE - 4 : $urandom_range(0, SIDE-1);
            hot_col = (p % 2 == 0) ? SIDE - 4 : $urandom_range(0, SIDE-1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_random_item(hot_row, hot_col);
        end
        wait_drained();

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ktte_pkg.sv
hw/rtl/ktte_ram.sv
hw/rtl/ktte_eval.sv
hw/rtl/kawasaki_two_temperature_exchange.sv
bench/tb_kawasaki_two_temperature_exchange.sv
